// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mrr_pkg.sv =====
`timescale 1ns / 1ps

package mrr_pkg;

    // field widths
    localparam int WORD_W = 31;
    localparam int SPAN_W = WORD_W + 1;
    localparam int MULT_W = 15;

    // generator constants
    localparam logic [WORD_W-1:0] MODULUS    = 31'h7FFF_FFFF;
    localparam logic [MULT_W-1:0] MULTIPLIER = 15'd16807;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // one classified request with its advanced generator state
    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] gen;
        logic [SPAN_W-1:0] span;
        logic              bad;
    } mrr_job_t;

endpackage

// ===== sv/minstd_range_random.sv =====
`timescale 1ns / 1ps

// Park-Miller minimal standard generator mapped onto an inclusive range.
// Each request word (range_low, range_high) advances the generator by
// state * 16807 mod (2^31 - 1) and returns range_low + floor(state * span /
// (2^31 - 1)) with span = range_high - range_low + 1, in exact integers;
// range_high below range_low returns range_low with range_bad set. The front
// end takes no new request while it folds the last one or while the queue is
// full: the generator recurrence is a registered 31x15 multiply followed by a
// Mersenne fold in the next cycle. A four-entry job queue decouples it from
// the back end, a three-stage pipeline (31x32 multiply, split, offset) that
// delivers one result per cycle while rsp_stall is low and jobs are queued.
// Writing seed_data with seed_we reloads the generator at once; write it only
// while no request is outstanding. Reset loads the generator with 1.
module minstd_range_random import mrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [WORD_W-1:0] seed_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [WORD_W-1:0] range_low,
    input  logic [WORD_W-1:0] range_high,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [WORD_W-1:0] value,
    output logic              range_bad
);

    logic     q_full, q_push, q_pop, q_empty;
    mrr_job_t push_job, pop_job;

    // request intake and generator
    mrr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_data  (seed_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .range_low  (range_low),
        .range_high (range_high),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_job)
    );

    // job queue
    mrr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_job)
    );

    // range mapping pipeline
    mrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (pop_job),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .value     (value),
        .range_bad (range_bad)
    );

endmodule

// ===== sv/mrr_front.sv =====
`timescale 1ns / 1ps

module mrr_front import mrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seed_we,
    input  logic [WORD_W-1:0] seed_data,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [WORD_W-1:0] range_low,
    input  logic [WORD_W-1:0] range_high,
    input  logic              q_full,
    output logic              q_push,
    output mrr_job_t          q_data
);

    typedef enum logic [1:0] {
        ST_TAKE = 2'b01,
        ST_FOLD = 2'b10
    } front_state_t;

    localparam int PROD_W = WORD_W + MULT_W;

    front_state_t              fsm_reg, fsm_next;
    logic [WORD_W-1:0]         gen_reg, gen_next;
    logic [PROD_W-1:0]         prod_reg;
    logic [WORD_W-1:0]         lo_reg;
    logic [SPAN_W-1:0]         span_reg;
    logic                      bad_reg;
    logic                      take;
    logic [SPAN_W-1:0]         fold_sum;
    logic [WORD_W-1:0]         fold_gen;

    // take a request only when the queue has room for it next cycle
    assign req_stall = (fsm_reg != ST_TAKE) || q_full;
    assign take      = req_valid && !req_stall;

    // mersenne fold of the registered product, one conditional subtract
    assign fold_sum = {1'b0, prod_reg[WORD_W-1:0]}
                    + {{(SPAN_W-MULT_W){1'b0}}, prod_reg[PROD_W-1:WORD_W]};
    always_comb
    begin
        if (fold_sum >= {1'b0, MODULUS})
        begin
            fold_gen = WORD_W'(fold_sum - {1'b0, MODULUS});
        end
        else
        begin
            fold_gen = fold_sum[WORD_W-1:0];
        end
    end

    // sequencer and generator update
    always_comb
    begin
        fsm_next = fsm_reg;
        gen_next = gen_reg;
        case (fsm_reg)
            ST_TAKE:
            begin
                if (take)
                begin
                    fsm_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                gen_next = fold_gen;
                fsm_next = ST_TAKE;
            end
            default:
            begin
                fsm_next = ST_TAKE;
            end
        endcase
        if (seed_we)
        begin
            gen_next = seed_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg <= ST_TAKE;
            gen_reg <= WORD_W'(1);
        end
        else
        begin
            fsm_reg <= fsm_next;
            gen_reg <= gen_next;
        end
    end

    // classify the request and start the state multiply
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prod_reg <= {{MULT_W{1'b0}}, gen_reg} * {{WORD_W{1'b0}}, MULTIPLIER};
            lo_reg   <= range_low;
            span_reg <= {1'b0, range_high} - {1'b0, range_low} + SPAN_W'(1);
            bad_reg  <= (range_high < range_low);
        end
    end

    // hand the job over once the new state is known
    assign q_push      = (fsm_reg == ST_FOLD);
    assign q_data.lo   = lo_reg;
    assign q_data.gen  = fold_gen;
    assign q_data.span = span_reg;
    assign q_data.bad  = bad_reg;

endmodule

// ===== sv/mrr_queue.sv =====
`timescale 1ns / 1ps

module mrr_queue import mrr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mrr_job_t push_data,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output mrr_job_t pop_data
);

    mrr_job_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/mrr_back.sv =====
`timescale 1ns / 1ps

module mrr_back import mrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  mrr_job_t          q_data,
    output logic              q_pop,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [WORD_W-1:0] value,
    output logic              range_bad
);

    localparam int PROD_W = WORD_W + SPAN_W;
    localparam int HIGH_W = PROD_W - WORD_W;
    localparam int SUM_W  = HIGH_W + 1;

    // scaling stage
    logic                s1_valid_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [WORD_W-1:0]   s1_lo_reg;
    logic                s1_bad_reg;
    // split stage
    logic                s2_valid_reg;
    logic [HIGH_W-1:0]   s2_high_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [WORD_W-1:0]   s2_lo_reg;
    logic                s2_bad_reg;
    // output register
    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_value_reg;
    logic                out_bad_reg;

    logic                out_adv, s2_adv, s1_adv;
    logic [1:0]          wraps;
    logic [SUM_W-1:0]    mapped;

    // pipeline moves where the next stage is free
    assign out_adv = !out_valid_reg || !rsp_stall;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign q_pop   = s1_adv && !q_empty;

    // p / (2^31-1) = a + floor((a + b) / (2^31-1)) with p = a*2^31 + b
    always_comb
    begin
        if (s2_sum_reg >= {1'b0, MODULUS, 1'b0})
        begin
            wraps = 2'd2;
        end
        else if (s2_sum_reg >= {2'b0, MODULUS})
        begin
            wraps = 2'd1;
        end
        else
        begin
            wraps = 2'd0;
        end
    end
    assign mapped = {2'b0, s2_lo_reg} + {1'b0, s2_high_reg} + {{(SUM_W-2){1'b0}}, wraps};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // state times span
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_prod_reg <= {{SPAN_W{1'b0}}, q_data.gen} * {{WORD_W{1'b0}}, q_data.span};
            s1_lo_reg   <= q_data.lo;
            s1_bad_reg  <= q_data.bad;
        end
    end

    // split the product into high and low halves
    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            s2_high_reg <= s1_prod_reg[PROD_W-1:WORD_W];
            s2_sum_reg  <= {1'b0, s1_prod_reg[PROD_W-1:WORD_W]}
                         + {{(SUM_W-WORD_W){1'b0}}, s1_prod_reg[WORD_W-1:0]};
            s2_lo_reg   <= s1_lo_reg;
            s2_bad_reg  <= s1_bad_reg;
        end
    end

    // final offset, inverted range passes the low bound through
    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            out_value_reg <= s2_bad_reg ? s2_lo_reg : mapped[WORD_W-1:0];
            out_bad_reg   <= s2_bad_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign range_bad = out_bad_reg;

endmodule

// ===== sv/mrr_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mrr_checker import mrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_stall,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  logic [WORD_W-1:0] value,
    input  logic              range_bad
);

    logic          req_take, rsp_take, rsp_held;
    logic [WORD_W:0] rsp_word;
    logic [3:0]    pending_reg;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;
    assign rsp_held = rsp_valid && rsp_stall;
    assign rsp_word = {range_bad, value};

    // words accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 4'(req_take) - 4'(rsp_take);
        end
    end

    // a stalled result stays put
    `CHK_ASSERT(a_hold, clk, rst_n, rsp_held |=> rsp_valid && $stable(rsp_word), "held word changed")
    // no result without an outstanding request
    `CHK_ASSERT(a_rsp_owed, clk, rst_n, rsp_valid |-> pending_reg != 4'd0, "result without request")
    // front end with queue holds at most four words, the pipeline three more
    `CHK_ASSERT(a_pending_max, clk, rst_n, pending_reg <= 4'd7, "too many words in flight")
    // the fold cycle blocks the next request
    `CHK_ASSERT(a_fold_stall, clk, rst_n, req_take |=> req_stall, "request taken during fold")
    // nothing comes out in the cycle after a reset edge
    `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !rsp_valid, "result during reset")

endmodule

bind minstd_range_random mrr_checker u_chk (.*);
